### hw/rtl/hlfd_pkg.sv
// ----------------------------------------------------------------------------
// Header-length frame deframer package
// Shared constants, event codes and the structs that pass between the
// front end, the command queue and the release engine.
// ----------------------------------------------------------------------------
package hlfd_pkg;

    localparam int PAYLOAD_DEPTH = 63;
    localparam int LEN_W         = 6;
    localparam int SLOT_W        = 6;
    localparam int CMD_DEPTH     = 4;

    localparam logic [7:0] LEN_MASK   = 8'h3F;
    localparam logic [7:0] DELIM_FLAG = 8'h40;
    localparam logic [7:0] FINAL_FLAG = 8'h80;

    localparam logic [1:0] EV_PAYLOAD = 2'd0;
    localparam logic [1:0] EV_DELIM   = 2'd1;
    localparam logic [1:0] EV_FINAL   = 2'd2;

    // One command per input byte that produces results.
    typedef struct packed {
        logic             delim;
        logic             payload;
        logic             fin;
        logic             bank;
        logic [LEN_W-1:0] len;
    } t_cmd;

    // Payload buffer write from the front end.
    typedef struct packed {
        logic              en;
        logic              bank;
        logic [SLOT_W-1:0] slot;
        logic [7:0]        data;
    } t_wr;

    // The release engine is finished reading a buffer bank.
    typedef struct packed {
        logic done;
        logic bank;
    } t_rel;

endpackage

### hw/rtl/hlfd_front.sv
// ----------------------------------------------------------------------------
// Deframer front end
// Parses headers, tracks the payload position, writes payload bytes into
// one of two buffer banks and issues release commands.
// ----------------------------------------------------------------------------
module hlfd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [7:0]    i_stream_byte,
    output logic          o_full,
    input  logic          i_fifo_full,
    output hlfd_pkg::t_cmd o_cmd,
    output logic          o_cmd_push,
    output hlfd_pkg::t_wr o_wr,
    input  hlfd_pkg::t_rel i_rel,
    output logic [1:0]    o_busy
);
    import hlfd_pkg::*;

    logic             r_active, n_active;
    logic [SLOT_W-1:0] r_count, n_count;
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_fin, n_fin;
    logic             r_bank, n_bank;
    logic [1:0]       r_busy, n_busy;

    logic [7:0]       w_masked;
    logic [LEN_W-1:0] w_hdr_len;
    logic             w_hdr_delim;
    logic             w_hdr_fin;
    logic             w_accept;
    logic [SLOT_W:0]  w_count_inc;
    logic             w_frame_done;

    assign w_masked    = i_stream_byte & LEN_MASK;
    assign w_hdr_len   = w_masked[LEN_W-1:0];
    assign w_hdr_delim = |(i_stream_byte & DELIM_FLAG);
    assign w_hdr_fin   = |(i_stream_byte & FINAL_FLAG);

    // A payload byte may not land in a bank that is still being released.
    assign o_full   = i_fifo_full || (r_active && r_busy[r_bank]);
    assign w_accept = i_push && !o_full;

    assign w_count_inc  = {1'b0, r_count} + {{SLOT_W{1'b0}}, 1'b1};
    assign w_frame_done = r_active && (w_count_inc == {1'b0, r_len});

    always_comb begin
        if (!r_active) begin
            o_cmd.delim   = w_hdr_delim;
            o_cmd.payload = 1'b0;
            o_cmd.fin     = w_hdr_fin && (w_hdr_len == '0);
            o_cmd.bank    = r_bank;
            o_cmd.len     = w_hdr_len;
            o_cmd_push    = w_accept && (w_hdr_delim || (w_hdr_fin && (w_hdr_len == '0)));
        end else begin
            o_cmd.delim   = 1'b0;
            o_cmd.payload = 1'b1;
            o_cmd.fin     = r_fin;
            o_cmd.bank    = r_bank;
            o_cmd.len     = r_len;
            o_cmd_push    = w_accept && w_frame_done;
        end
    end

    assign o_wr.en   = w_accept && r_active;
    assign o_wr.bank = r_bank;
    assign o_wr.slot = r_count;
    assign o_wr.data = i_stream_byte;
    assign o_busy    = r_busy;

    always_comb begin
        n_active = r_active;
        n_count  = r_count;
        n_len    = r_len;
        n_fin    = r_fin;
        n_bank   = r_bank;
        n_busy   = r_busy;
        if (i_rel.done) begin
            n_busy[i_rel.bank] = 1'b0;
        end
        if (w_accept) begin
            if (!r_active) begin
                if (w_hdr_len != '0) begin
                    n_active = 1'b1;
                    n_count  = '0;
                    n_len    = w_hdr_len;
                    n_fin    = w_hdr_fin;
                end
            end else if (w_frame_done) begin
                // The filled bank goes to the release engine; collect into the other.
                n_active       = 1'b0;
                n_busy[r_bank] = 1'b1;
                n_bank         = ~r_bank;
            end else begin
                n_count = w_count_inc[SLOT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_count  <= '0;
            r_bank   <= 1'b0;
            r_busy   <= '0;
        end else begin
            r_active <= n_active;
            r_count  <= n_count;
            r_bank   <= n_bank;
            r_busy   <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len <= n_len;
        r_fin <= n_fin;
    end

endmodule

### hw/rtl/hlfd_cmd_fifo.sv
// ----------------------------------------------------------------------------
// Deframer command queue
// Short first-in first-out queue of release commands between the front end
// and the release engine.
// ----------------------------------------------------------------------------
module hlfd_cmd_fifo #(
    parameter int DEPTH = hlfd_pkg::CMD_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  hlfd_pkg::t_cmd i_data,
    output logic           o_full,
    input  logic           i_pop,
    output hlfd_pkg::t_cmd o_data,
    output logic           o_empty
);
    import hlfd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_cnt == CNT_W'(DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign o_data    = r_mem[r_rptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (w_do_push) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_do_pop && !w_do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

### hw/rtl/hlfd_back.sv
// ----------------------------------------------------------------------------
// Deframer release engine
// Holds the two-bank payload buffer and turns each command into delimiter,
// payload and final events through a registered result stage.
// ----------------------------------------------------------------------------
module hlfd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  hlfd_pkg::t_cmd i_cmd,
    input  logic           i_cmd_empty,
    output logic           o_cmd_pop,
    input  hlfd_pkg::t_wr  i_wr,
    output hlfd_pkg::t_rel o_rel,
    input  logic           i_pop,
    output logic           o_empty,
    output logic [1:0]     o_event_kind,
    output logic [7:0]     o_payload_byte,
    output logic [5:0]     o_payload_length,
    output logic           o_run_last
);
    import hlfd_pkg::*;

    localparam int MEM_DEPTH = 2 * (1 << SLOT_W);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DELIM = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_DATA  = 3'd3;
    localparam logic [2:0] S_FINAL = 3'd4;

    logic [7:0]        r_mem [MEM_DEPTH];
    logic [7:0]        r_rd_data;

    logic [2:0]        r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [SLOT_W-1:0] r_idx, n_idx;

    logic              r_out_valid;
    logic [1:0]        r_out_kind;
    logic [7:0]        r_out_byte;
    logic [LEN_W-1:0]  r_out_len;
    logic              r_out_last;

    logic              w_out_free;
    logic              w_rd_en;
    logic              w_load;
    logic [1:0]        w_ld_kind;
    logic [7:0]        w_ld_byte;
    logic              w_ld_last;
    logic              w_last_byte;

    assign w_out_free  = !r_out_valid || i_pop;
    assign w_last_byte = ({1'b0, r_idx} + {{SLOT_W{1'b0}}, 1'b1}) == {1'b0, r_cmd.len};

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_idx      = r_idx;
        o_cmd_pop  = 1'b0;
        w_rd_en    = 1'b0;
        w_load     = 1'b0;
        w_ld_kind  = EV_PAYLOAD;
        w_ld_byte  = 8'd0;
        w_ld_last  = 1'b0;
        o_rel.done = 1'b0;
        o_rel.bank = r_cmd.bank;
        case (r_state)
            S_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_idx     = '0;
                    if (i_cmd.delim) begin
                        n_state = S_DELIM;
                    end else if (i_cmd.payload) begin
                        n_state = S_READ;
                    end else begin
                        n_state = S_FINAL;
                    end
                end
            end
            S_DELIM: begin
                if (w_out_free) begin
                    w_load    = 1'b1;
                    w_ld_kind = EV_DELIM;
                    w_ld_last = !(r_cmd.payload || r_cmd.fin);
                    if (r_cmd.payload) begin
                        n_state = S_READ;
                    end else if (r_cmd.fin) begin
                        n_state = S_FINAL;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_READ: begin
                w_rd_en = 1'b1;
                n_state = S_DATA;
            end
            S_DATA: begin
                if (w_out_free) begin
                    w_load    = 1'b1;
                    w_ld_kind = EV_PAYLOAD;
                    w_ld_byte = r_rd_data;
                    w_ld_last = w_last_byte && !r_cmd.fin;
                    if (w_last_byte) begin
                        // Last read of this bank is done; the front end may refill it.
                        o_rel.done = 1'b1;
                        n_state    = r_cmd.fin ? S_FINAL : S_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_READ;
                    end
                end
            end
            S_FINAL: begin
                if (w_out_free) begin
                    w_load    = 1'b1;
                    w_ld_kind = EV_FINAL;
                    w_ld_last = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[{i_wr.bank, i_wr.slot}] <= i_wr.data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[{r_cmd.bank, r_idx}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_idx <= n_idx;
        if (w_load) begin
            r_out_kind <= w_ld_kind;
            r_out_byte <= w_ld_byte;
            r_out_len  <= r_cmd.len;
            r_out_last <= w_ld_last;
        end
    end

    assign o_empty          = !r_out_valid;
    assign o_event_kind     = r_out_kind;
    assign o_payload_byte   = r_out_byte;
    assign o_payload_length = r_out_len;
    assign o_run_last       = r_out_last;

endmodule

### hw/rtl/header_length_frame_deframer.sv
// ----------------------------------------------------------------------------
// Header-length frame deframer
// Splits a byte stream of length-prefixed frames into delimiter, payload
// and final events.
// ----------------------------------------------------------------------------
// Usage:
// Input bytes are written like into a queue: a transfer happens on a clock
// edge with push high and full low. Results are read like from a queue:
// while empty is low the oldest event is on the result ports, and a
// transfer happens on a clock edge with pop high.
// The front end takes one byte per cycle. It stalls (full high) when the
// command queue is full, or when a payload byte would land in a buffer bank
// whose previous frame is still being released; two banks let the next
// frame be collected while the last one goes out.
// With the release engine idle, the first event of a byte goes through the
// command queue and the engine's state register, and for a payload byte the
// buffer read register, into the result register. The engine takes a
// command from the queue, then loads a delimiter or final event into the
// result register; a payload byte is read from the buffer, then loaded.
// A stall on pop only holds the result register; the engine and then the
// front end back up behind it, and nothing is lost.
// Reset clears the frame parser, the queue and the result register; the
// payload buffer needs no clearing, since only bytes of the current frame
// are read.
// ----------------------------------------------------------------------------
module header_length_frame_deframer #(
    parameter int CMD_FIFO_DEPTH = hlfd_pkg::CMD_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_stream_byte,
    input  logic       pop,
    output logic       empty,
    output logic [1:0] o_event_kind,
    output logic [7:0] o_payload_byte,
    output logic [5:0] o_payload_length,
    output logic       o_run_last
);
    import hlfd_pkg::*;

    t_cmd       w_cmd_in;
    t_cmd       w_cmd_out;
    logic       w_cmd_push;
    logic       w_cmd_pop;
    logic       w_fifo_full;
    logic       w_fifo_empty;
    t_wr        w_wr;
    t_rel       w_rel;
    logic [1:0] w_busy;

    hlfd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_stream_byte (i_stream_byte),
        .o_full        (full),
        .i_fifo_full   (w_fifo_full),
        .o_cmd         (w_cmd_in),
        .o_cmd_push    (w_cmd_push),
        .o_wr          (w_wr),
        .i_rel         (w_rel),
        .o_busy        (w_busy)
    );

    hlfd_cmd_fifo #(
        .DEPTH (CMD_FIFO_DEPTH)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_data  (w_cmd_in),
        .o_full  (w_fifo_full),
        .i_pop   (w_cmd_pop),
        .o_data  (w_cmd_out),
        .o_empty (w_fifo_empty)
    );

    hlfd_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd_out),
        .i_cmd_empty      (w_fifo_empty),
        .o_cmd_pop        (w_cmd_pop),
        .i_wr             (w_wr),
        .o_rel            (w_rel),
        .i_pop            (pop),
        .o_empty          (empty),
        .o_event_kind     (o_event_kind),
        .o_payload_byte   (o_payload_byte),
        .o_payload_length (o_payload_length),
        .o_run_last       (o_run_last)
    );

    // Non-payload events carry a zero data byte.
    a_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_event_kind != EV_PAYLOAD)) |-> (o_payload_byte == 8'd0))
        else $error("non-payload event with nonzero data byte");

    // The front end never overwrites a bank that is still being released.
    a_bank_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr.en |-> !w_busy[w_wr.bank])
        else $error("payload write into a busy bank");

    // A command is never offered to a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_push |-> !w_fifo_full)
        else $error("command queue overflow");

    // A bank is only released after it was handed over.
    a_rel_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rel.done |-> w_busy[w_rel.bank])
        else $error("release of a bank that was not handed over");

endmodule
